// ===== hdl/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// Types, character codes and the letter table for the Morse text decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharA     = 8'h61;

  localparam int NumLetters = 26;
  localparam logic [2:0] MaxSymbols = 3'd4;
  localparam logic [1:0] SpaceSat   = 2'd3;

  localparam int OutDepth = 4;
  localparam int PtrW     = $clog2(OutDepth);
  localparam int CntW     = $clog2(OutDepth + 1);

  localparam logic [2:0] LetterLen [NumLetters] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [3:0] LetterBits [NumLetters] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef struct packed {
    logic [7:0] symbol_char;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] decoded_char;
    logic       last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [3:0] pattern;
    logic [2:0] length;
    logic       invalid;
    logic [1:0] run;
  } tok_state_t;

  typedef struct packed {
    tok_state_t st;
    logic       letter_v;
    logic [7:0] letter;
    logic       space_v;
  } gap_res_t;

  function automatic gap_res_t handle_gap(tok_state_t s);
    gap_res_t r;
    r.letter_v = 1'b0;
    r.letter   = CharSpace;
    if (!s.invalid && s.length != 3'd0 && s.length <= MaxSymbols) begin
      for (int i = 0; i < NumLetters; i++) begin
        if (!r.letter_v && LetterLen[i] == s.length && LetterBits[i] == s.pattern) begin
          r.letter_v = 1'b1;
          r.letter   = CharA + 8'(i);
        end
      end
    end
    r.st.pattern = 4'd0;
    r.st.length  = 3'd0;
    r.st.invalid = 1'b0;
    r.st.run     = (s.run < SpaceSat) ? s.run + 2'd1 : s.run;
    r.space_v    = (r.st.run == SpaceSat);
    return r;
  endfunction

endpackage

// ===== hdl/morse_text_decoder_top.sv =====
// ----------------------------------------------------------------------------
// morse_text_decoder_top
// Decodes a stream of dot, dash and space characters into lower-case text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one character
//   beat per cycle while in_stall_o is low, with an end-of-message flag.
//   Output channel (out_valid_o / out_stall_i / out_data_o) delivers decoded
//   letters and spaces; each input beat causes zero, one or two output beats,
//   the last one marked with last_of_run.
//   Each output beat is registered in the output queue before it is visible.
//   Throughput: one input beat per cycle as long as the receiver drains at
//   least as many beats as are produced. Token state is updated as the beat
//   is taken; results go to a four-entry output queue, and in_stall_o rises
//   while fewer than two entries are free.
//   Reset clears the token, the space run and the queue.
//   While the receiver stalls, the queue holds its head beat and fills; input
//   stalls once it cannot absorb the two results one beat may cause.
// ----------------------------------------------------------------------------
module morse_text_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtd_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtd_pkg::out_beat_t  out_data_o
);

  mtd_pkg::tok_state_t tok_q, tok_d;
  mtd_pkg::out_beat_t  queue_q [mtd_pkg::OutDepth];
  logic [mtd_pkg::PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mtd_pkg::CntW-1:0] cnt_q, cnt_d;

  mtd_pkg::gap_res_t gap_char, gap_end;
  mtd_pkg::tok_state_t st_char;
  logic [7:0] cand_char [4];
  logic       cand_v [4];
  mtd_pkg::out_beat_t res0, res1;
  logic [1:0] n_res;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign in_stall_o  = cnt_q > mtd_pkg::CntW'(mtd_pkg::OutDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_comb begin
    st_char  = tok_q;
    gap_char = mtd_pkg::handle_gap(tok_q);
    case (in_data_i.symbol_char)
      mtd_pkg::CharDot, mtd_pkg::CharDash: begin
        st_char.run = 2'd0;
        if (tok_q.length < mtd_pkg::MaxSymbols) begin
          if (in_data_i.symbol_char == mtd_pkg::CharDash) begin
            st_char.pattern = tok_q.pattern | (4'd1 << tok_q.length[1:0]);
          end
          st_char.length = tok_q.length + 3'd1;
        end else begin
          st_char.invalid = 1'b1;
        end
      end
      mtd_pkg::CharSpace: begin
        st_char = gap_char.st;
      end
      default: begin
        st_char.run     = 2'd0;
        st_char.invalid = 1'b1;
      end
    endcase
    gap_end = mtd_pkg::handle_gap(st_char);

    cand_v[0]    = (in_data_i.symbol_char == mtd_pkg::CharSpace) && gap_char.letter_v;
    cand_char[0] = gap_char.letter;
    cand_v[1]    = (in_data_i.symbol_char == mtd_pkg::CharSpace) && gap_char.space_v;
    cand_char[1] = mtd_pkg::CharSpace;
    cand_v[2]    = in_data_i.end_of_message && gap_end.letter_v;
    cand_char[2] = gap_end.letter;
    cand_v[3]    = in_data_i.end_of_message && gap_end.space_v;
    cand_char[3] = mtd_pkg::CharSpace;

    res0  = '{decoded_char: mtd_pkg::CharSpace, last_of_run: 1'b0};
    res1  = '{decoded_char: mtd_pkg::CharSpace, last_of_run: 1'b0};
    n_res = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        if (n_res == 2'd0) begin
          res0.decoded_char = cand_char[k];
          n_res = 2'd1;
        end else if (n_res == 2'd1) begin
          res1.decoded_char = cand_char[k];
          n_res = 2'd2;
        end
      end
    end
    res0.last_of_run = (n_res == 2'd1);
    res1.last_of_run = (n_res == 2'd2);

    tok_d = tok_q;
    if (in_acc) begin
      tok_d = in_data_i.end_of_message ? '0 : st_char;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = cnt_d + mtd_pkg::CntW'(n_res);
    end
    if (out_acc) begin
      cnt_d = cnt_d - mtd_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      tok_q <= tok_d;
      cnt_q <= cnt_d;
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + mtd_pkg::PtrW'(n_res);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + mtd_pkg::PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      queue_q[wr_ptr_q + mtd_pkg::PtrW'(1)] <= res1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mtd_pkg::CntW'(mtd_pkg::OutDepth))
    else $error("output queue overfilled");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.length <= mtd_pkg::MaxSymbols)
    else $error("token length out of range");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q <= mtd_pkg::CntW'(mtd_pkg::OutDepth - 2))
    else $error("input taken without room for its results");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_message) |=> tok_q == '0)
    else $error("token state not cleared at end of message");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != mtd_pkg::CntW'(mtd_pkg::OutDepth)) |->
      wr_ptr_q != rd_ptr_q)
    else $error("queue pointers disagree with fill count");

endmodule

// ===== verif/morse_text_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_text_decoder_top_tb
// Self-checking bench for the Morse text decoder. Character beats, a mix of
// letter codes, unknown and overlong tokens, stray bytes, space runs and
// end-of-message flags, go in with random gaps on both channels. A predictor
// tracks the token and space run and queues the letters and spaces each beat
// should yield. Every output beat is checked field by field against them.
// ----------------------------------------------------------------------------

class morse_decode_board;
  logic [3:0] pattern;
  logic [2:0] length;
  logic       invalid;
  logic [1:0] space_run;
  logic [2:0] code_len  [26];
  logic [3:0] code_bits [26];
  mtd_pkg::out_beat_t pending_chars[$];
  mtd_pkg::out_beat_t step_chars[$];
  int fails;

  function new();
    code_len  = '{3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
                  3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
                  3'd4, 3'd4};
    code_bits = '{4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2,
                  4'd3, 4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9,
                  4'd13, 4'd3};
    pattern   = '0;
    length    = '0;
    invalid   = 1'b0;
    space_run = '0;
    fails     = 0;
  endfunction

  function void add_char(logic [7:0] ch);
    mtd_pkg::out_beat_t b;
    b.decoded_char = ch;
    b.last_of_run  = 1'b0;
    if (step_chars.size() < 2) step_chars.push_back(b);
  endfunction

  function void close_token();
    bit found;
    found = 1'b0;
    if (!invalid && length != 3'd0) begin
      for (int i = 0; i < 26; i++) begin
        if (!found && code_len[i] == length && code_bits[i] == pattern) begin
          found = 1'b1;
          add_char(mtd_pkg::CharA + 8'(i));
        end
      end
    end
    pattern = '0;
    length  = '0;
    invalid = 1'b0;
    if (space_run < 2'd3) space_run++;
    if (space_run == 2'd3) add_char(mtd_pkg::CharSpace);
  endfunction

  function void note_char(mtd_pkg::in_beat_t b);
    step_chars.delete();
    if (b.symbol_char == mtd_pkg::CharDot || b.symbol_char == mtd_pkg::CharDash) begin
      space_run = '0;
      if (length < 3'd4) begin
        if (b.symbol_char == mtd_pkg::CharDash) pattern[length[1:0]] = 1'b1;
        length++;
      end else begin
        invalid = 1'b1;
      end
    end else if (b.symbol_char == mtd_pkg::CharSpace) begin
      close_token();
    end else begin
      space_run = '0;
      invalid   = 1'b1;
    end
    if (b.end_of_message) begin
      close_token();
      pattern   = '0;
      length    = '0;
      invalid   = 1'b0;
      space_run = '0;
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last_of_run = 1'b1;
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endfunction

  function void check_char(mtd_pkg::out_beat_t got);
    mtd_pkg::out_beat_t want;
    if (pending_chars.size() == 0) begin
      $error("unexpected beat: decoded_char %h last_of_run %b",
             got.decoded_char, got.last_of_run);
      fails++;
    end else begin
      want = pending_chars.pop_front();
      if (got.decoded_char !== want.decoded_char) begin
        $error("decoded_char expected %h actual %h", want.decoded_char, got.decoded_char);
        fails++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run expected %b actual %b", want.last_of_run, got.last_of_run);
        fails++;
      end
    end
  endfunction

  function int pending();
    return pending_chars.size();
  endfunction
endclass

module morse_text_decoder_top_tb;

  localparam int QuietLimit = 2000;
  localparam int RandomItems = 1800;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mtd_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mtd_pkg::out_beat_t out_data_o;

  morse_decode_board board;
  bit idle_on;
  int sent;
  int quiet_cycles;

  morse_text_decoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_char(input logic [7:0] ch, input logic eom);
    mtd_pkg::in_beat_t b;
    b.symbol_char    = ch;
    b.end_of_message = eom;
    while (idle_on && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_char(b);
    sent++;
  endtask

  task automatic send_letter(input int idx, input bit eom_last);
    int n;
    n = int'(board.code_len[idx]);
    for (int k = 0; k < n; k++) begin
      send_char(board.code_bits[idx][k] ? mtd_pkg::CharDash : mtd_pkg::CharDot,
                eom_last && k == n - 1);
    end
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_char(out_data_o);
    out_stall_i <= idle_on && ($urandom_range(0, 99) < 24);
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  r;
    int  n;
    int  gaps;
    bit  paused_early;
    bit  paused_late;
    board        = new();
    idle_on      = 1'b1;
    sent         = 0;
    quiet_cycles = 0;
    paused_early = 1'b0;
    paused_late  = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_char(mtd_pkg::CharDot, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    send_letter(25, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    repeat (5) send_char(mtd_pkg::CharDot, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    send_char(mtd_pkg::CharDot, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    send_char(mtd_pkg::CharDot, 1'b0);
    send_char(mtd_pkg::CharDot, 1'b0);
    send_char(mtd_pkg::CharDash, 1'b0);
    send_char(mtd_pkg::CharDash, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b0);
    send_char(mtd_pkg::CharSpace, 1'b1);
    send_char(8'hFF, 1'b1);
    drain_all();

    sent = 0;
    while (sent < RandomItems) begin
      idle_on = !(sent >= 700 && sent < 1000);
      if (!paused_early && sent >= 500) begin
        paused_early = 1'b1;
        drain_all();
      end
      if (!paused_late && sent >= 1400) begin
        paused_late = 1'b1;
        drain_all();
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_letter($urandom_range(0, 25), $urandom_range(0, 19) == 0);
        gaps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        for (int g = 0; g < gaps; g++) begin
          send_char(mtd_pkg::CharSpace, g == gaps - 1 && $urandom_range(0, 19) == 0);
        end
      end else if (r < 78) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          send_char($urandom_range(0, 1) ? mtd_pkg::CharDash : mtd_pkg::CharDot, 1'b0);
        end
        send_char(mtd_pkg::CharSpace, $urandom_range(0, 9) == 0);
      end else if (r < 90) begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          send_char(mtd_pkg::CharSpace, k == n - 1 && $urandom_range(0, 3) == 0);
        end
      end
    end

    drain_all();
    repeat (10) @(posedge clk_i);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
